// ===== rtl/min_tracking_stack_defines.svh =====
// assertion macros for the min tracking stack checker
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// same-cycle implication
`define MTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mts_pkg.sv =====
// types and codes shared by the min tracking stack modules
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] min_value;
    logic [6:0]         depth;
    logic               is_empty;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_full;
  } ctl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mts_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/mts_ctrl.sv =====
// controller: sequences accept and execute of one operation
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                out_ready,
  input  wire mts_pkg::ctl_stat_t  stat,
  output logic                     in_ready,
  output mts_pkg::ctl_cmd_t        cmd
);

  mts_pkg::state_t state_r;
  mts_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      mts_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = mts_pkg::S_EXEC;
        end
      end
      mts_pkg::S_EXEC: begin
        // hold while the output register is occupied and not being taken
        if (!stat.out_full || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = mts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mts_datapath.sv =====
// datapath: value and minima stores, counts, minimum tracking, result register
`timescale 1ns / 1ps
`default_nettype none

module mts_datapath #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mts_pkg::in_item_t   in_data,
  input  wire mts_pkg::ctl_cmd_t   cmd,
  input  wire logic                out_ready,
  output mts_pkg::ctl_stat_t       stat,
  output logic                     out_valid,
  output mts_pkg::out_item_t       out_data
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int EXT_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  mts_pkg::op_t              op_r;
  logic [DATA_WIDTH-1:0]     val_r;
  logic [CW-1:0]             vc_r;
  logic [CW-1:0]             vc_nxt;
  logic [CW-1:0]             mc_r;
  logic [CW-1:0]             mc_nxt;
  logic [DATA_WIDTH-1:0]     min_top_r;
  logic [DATA_WIDTH-1:0]     min_top_nxt;
  logic                      out_valid_r;
  mts_pkg::out_item_t        out_data_r;
  mts_pkg::out_item_t        res;

  logic                      full;
  logic                      push_min;
  logic                      v_wr_en;
  logic                      m_wr_en;
  logic [AW-1:0]             v_wr_addr;
  logic [AW-1:0]             m_wr_addr;
  logic [AW-1:0]             v_rd_addr;
  logic [AW-1:0]             m_rd_addr;
  logic [DATA_WIDTH-1:0]     v_rd_data;
  logic [DATA_WIDTH-1:0]     m_rd_data;
  logic signed [EXT_W-1:0]   pop_ext;
  logic signed [EXT_W-1:0]   min_ext;
  logic                      pop_ok;

  // top of value stack and the minima entry below the current top
  assign v_rd_addr = AW'(vc_r - CW'(1));
  assign m_rd_addr = AW'(mc_r - CW'(2));
  assign v_wr_addr = AW'(vc_r);
  assign m_wr_addr = AW'(mc_r);

  mts_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (v_wr_en),
    .wr_addr (v_wr_addr),
    .wr_data (val_r),
    .rd_addr (v_rd_addr),
    .rd_data (v_rd_data)
  );

  mts_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_minima_ram (
    .clk     (clk),
    .wr_en   (m_wr_en),
    .wr_addr (m_wr_addr),
    .wr_data (val_r),
    .rd_addr (m_rd_addr),
    .rd_data (m_rd_data)
  );

  assign full     = (vc_r == CW'(STACK_DEPTH));
  assign push_min = (mc_r == '0) || ($signed(val_r) <= $signed(min_top_r));
  assign pop_ext  = EXT_W'($signed(v_rd_data));
  assign min_ext  = EXT_W'($signed(min_top_nxt));

  always_comb begin
    vc_nxt      = vc_r;
    mc_nxt      = mc_r;
    min_top_nxt = min_top_r;
    v_wr_en     = 1'b0;
    m_wr_en     = 1'b0;
    pop_ok      = 1'b0;
    res.status  = mts_pkg::ST_OK;
    case (op_r)
      mts_pkg::OP_PUSH: begin
        if (full) begin
          res.status = mts_pkg::ST_OVERFLOW;
        end else begin
          v_wr_en = cmd.commit;
          vc_nxt  = vc_r + CW'(1);
          if (push_min) begin
            m_wr_en     = cmd.commit;
            mc_nxt      = mc_r + CW'(1);
            min_top_nxt = val_r;
          end
        end
      end
      mts_pkg::OP_POP: begin
        if (vc_r == '0) begin
          res.status = mts_pkg::ST_UNDERFLOW;
        end else begin
          pop_ok = 1'b1;
          vc_nxt = vc_r - CW'(1);
          if ((mc_r != '0) && (min_top_r == v_rd_data)) begin
            mc_nxt      = mc_r - CW'(1);
            min_top_nxt = m_rd_data;
          end
        end
      end
      default: begin
        res.status = mts_pkg::ST_OK;
      end
    endcase
    res.popped_value = pop_ok ? pop_ext[31:0] : 32'sd0;
    res.min_value    = ((vc_nxt != '0) && (mc_nxt != '0)) ? min_ext[31:0] : 32'sd0;
    res.depth        = 7'(vc_nxt);
    res.is_empty     = (vc_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= '0;
      mc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        vc_r        <= vc_nxt;
        mc_r        <= mc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= mts_pkg::op_t'(in_data.opcode);
      val_r <= DATA_WIDTH'($unsigned(in_data.push_value));
    end
    if (cmd.commit) begin
      min_top_r  <= min_top_nxt;
      out_data_r <= res;
    end
  end

  assign stat.out_full = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/min_tracking_stack.sv =====
// top level of the min tracking stack
//
//   channel  ports                         carries
//   in       in_valid  in_ready  in_data   opcode, push_value
//   out      out_valid out_ready out_data  popped_value, min_value, depth, is_empty, status
//
// an operation runs as an accept cycle, which issues reads of the top value and of the
// minima entry below the top, then an execute cycle, which uses the registered read data
// the result lands in the output register at the end of the execute cycle
// execute holds while the output register is full and not being taken
// synchronous reset empties both stacks at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mts_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mts_pkg::out_item_t      out_data
);

  mts_pkg::ctl_cmd_t  cmd;
  mts_pkg::ctl_stat_t stat;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/mts_checker.sv =====
// port-level checker for the min tracking stack, with its bind
`timescale 1ns / 1ps
`default_nettype none

`include "min_tracking_stack_defines.svh"

module mts_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire mts_pkg::out_item_t out_data
);

  `MTS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `MTS_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "transfer taken while busy")
  `MTS_ASSERT_IMP(a_empty_min, out_valid && out_data.is_empty, (out_data.depth == 7'd0) && (out_data.min_value == 32'sd0), "empty stack reports depth or minimum")
  `MTS_ASSERT_IMP(a_underflow, out_valid && (out_data.status == mts_pkg::ST_UNDERFLOW), out_data.is_empty && (out_data.popped_value == 32'sd0), "underflow on non-empty stack")

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

`default_nettype wire

// ===== tb/min_tracking_stack_tb.sv =====
// testbench for the min tracking stack: directed table, then random bursts against a model
`timescale 1ns / 1ps

module min_tracking_stack_tb;

  localparam int STACK_DEPTH = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    mts_pkg::op_t       op;
    logic signed [31:0] value;
    bit                 typed;
    logic signed [31:0] popped;
    logic signed [31:0] minv;
    logic [6:0]         depth;
    logic               empty;
    mts_pkg::status_t   status;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  mts_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  mts_pkg::out_item_t out_data;

  logic signed [31:0] val_stack [STACK_DEPTH];
  logic signed [31:0] min_stack [STACK_DEPTH];
  int                 val_depth = 0;
  int                 min_depth = 0;
  mts_pkg::out_item_t pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  dir_row_t dir_table [23] = '{
    '{mts_pkg::OP_POP, 32'sd0, 1'b1, 32'sd0, 32'sd0, 7'd0, 1'b1, mts_pkg::ST_UNDERFLOW},
    '{mts_pkg::OP_PUSH, 32'sh7fff_ffff, 1'b1, 32'sd0, 32'sh7fff_ffff, 7'd1, 1'b0,
      mts_pkg::ST_OK},
    '{mts_pkg::OP_PUSH, 32'sh8000_0000, 1'b1, 32'sd0, 32'sh8000_0000, 7'd2, 1'b0,
      mts_pkg::ST_OK},
    '{mts_pkg::OP_PUSH, 32'sh8000_0000, 1'b1, 32'sd0, 32'sh8000_0000, 7'd3, 1'b0,
      mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'sh1234_5678, 1'b1, 32'sh8000_0000, 32'sh8000_0000, 7'd2, 1'b0,
      mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'shffff_ffff, 1'b1, 32'sh8000_0000, 32'sh7fff_ffff, 7'd1, 1'b0,
      mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'sd0, 1'b1, 32'sh7fff_ffff, 32'sd0, 7'd0, 1'b1, mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'sd0, 1'b1, 32'sd0, 32'sd0, 7'd0, 1'b1, mts_pkg::ST_UNDERFLOW},
    '{mts_pkg::OP_PUSH, 32'sd5, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_PUSH, 32'sd7, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_PUSH, 32'sd5, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_PUSH, -32'sd3, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_PUSH, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_PUSH, 32'sh5555_5555, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_PUSH, 32'shaaaa_aaaa, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'shffff_ffff, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'sd0, 1'b0, 32'sd0, 32'sd0, 7'd0, 1'b0, mts_pkg::ST_OK},
    '{mts_pkg::OP_POP, 32'sd0, 1'b1, 32'sd0, 32'sd0, 7'd0, 1'b1, mts_pkg::ST_UNDERFLOW}
  };

  min_tracking_stack u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic mts_pkg::out_item_t apply_stack_op(input mts_pkg::in_item_t item);
    mts_pkg::out_item_t res;
    logic signed [31:0] top;
    res = '0;
    res.status = mts_pkg::ST_OK;
    if (item.opcode == mts_pkg::OP_PUSH) begin
      if (val_depth >= STACK_DEPTH) begin
        res.status = mts_pkg::ST_OVERFLOW;
      end else begin
        val_stack[val_depth] = item.push_value;
        val_depth++;
        if (min_depth == 0 ||
            $signed(item.push_value) <= $signed(min_stack[min_depth - 1])) begin
          if (min_depth < STACK_DEPTH) begin
            min_stack[min_depth] = item.push_value;
            min_depth++;
          end
        end
      end
    end else begin
      if (val_depth == 0) begin
        res.status = mts_pkg::ST_UNDERFLOW;
      end else begin
        top = val_stack[val_depth - 1];
        val_depth--;
        if (min_depth > 0 && min_stack[min_depth - 1] == top) min_depth--;
        res.popped_value = top;
      end
    end
    if (val_depth > 0 && min_depth > 0) res.min_value = min_stack[min_depth - 1];
    res.depth    = val_depth[6:0];
    res.is_empty = (val_depth == 0);
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed($urandom_range(8)) - 4;
      4: begin
        case ($urandom_range(3))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // called at a clock edge; returns at the edge where the transfer happens
  task automatic send_op(input mts_pkg::in_item_t item, input bit typed,
                         input mts_pkg::out_item_t typed_res);
    mts_pkg::out_item_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    res = apply_stack_op(item);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic run_bursts(input int n_items, input bit with_hold);
    int                sent;
    int                burst_len;
    int                push_pct;
    bit                first;
    mts_pkg::in_item_t item;
    sent  = 0;
    first = 1'b1;
    if (with_hold) hold_req <= hold_req + 1;
    while (sent < n_items) begin
      if (first) begin
        push_pct  = 95;
        burst_len = $urandom_range(70, 90);
      end else begin
        case ($urandom_range(3))
          0: begin
            push_pct  = 95;
            burst_len = $urandom_range(70, 90);
          end
          1: begin
            push_pct  = 5;
            burst_len = $urandom_range(40, 80);
          end
          default: begin
            push_pct  = $urandom_range(30, 70);
            burst_len = $urandom_range(5, 30);
          end
        endcase
      end
      first = 1'b0;
      repeat (burst_len) begin
        if (sent < n_items) begin
          item.opcode     = ($urandom_range(99) < push_pct) ? mts_pkg::OP_PUSH : mts_pkg::OP_POP;
          item.push_value = pick_value();
          send_op(item, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // receiver side, with a long hold-off when a burst run asks for one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    mts_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("popped_value", want.popped_value, out_data.popped_value);
        check_field("min_value", want.min_value, out_data.min_value);
        check_field("depth", 32'(want.depth), 32'(out_data.depth));
        check_field("is_empty", 32'(want.is_empty), 32'(out_data.is_empty));
        check_field("status", 32'(want.status), 32'(out_data.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("min_tracking_stack_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mts_pkg::in_item_t  item;
    mts_pkg::out_item_t typed_res;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    send_idle_pct = 29;
    recv_idle_pct = 73;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      item.opcode     = dir_table[i].op;
      item.push_value = dir_table[i].value;
      typed_res = '{dir_table[i].popped, dir_table[i].minv, dir_table[i].depth,
                    dir_table[i].empty, dir_table[i].status};
      send_op(item, dir_table[i].typed, typed_res);
    end

    run_bursts(PHASE_ITEMS, 1'b0);
    send_idle_pct = 73;
    recv_idle_pct = 29;
    run_bursts(PHASE_ITEMS, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_bursts(PHASE_ITEMS, 1'b1);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("min_tracking_stack_tb OK");
    end else begin
      $display("min_tracking_stack_tb NOT OK");
    end
    $finish;
  end

endmodule
